// ----- design/stq_pkg.sv -----
package stq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DELAY_W  = 16;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;
  localparam int PEND_W   = 5;

  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic               insert;
    logic               shift;
    logic [DELAY_W-1:0] new_delay;
    logic [TAG_W-1:0]   new_tag;
  } cell_cmd_t;

endpackage

// ----- design/stq_cell.sv -----
module stq_cell
  import stq_pkg::*;
(
  input  logic               clk,
  input  cell_cmd_t          cmd,
  input  logic               occupied,
  input  logic               left_gt,
  input  logic [DELAY_W-1:0] left_delay,
  input  logic [TAG_W-1:0]   left_tag,
  input  logic [DELAY_W-1:0] right_delay,
  input  logic [TAG_W-1:0]   right_tag,
  output logic [DELAY_W-1:0] delay_r,
  output logic [TAG_W-1:0]   tag_r,
  output logic               gt
);

  logic [DELAY_W-1:0] delay_nxt;
  logic [TAG_W-1:0]   tag_nxt;

  // Strictly greater keeps equal delays in arrival order.
  assign gt = occupied && (delay_r > cmd.new_delay);

  always_comb begin
    delay_nxt = delay_r;
    tag_nxt   = tag_r;
    if (cmd.insert) begin
      if (left_gt) begin
        delay_nxt = left_delay;
        tag_nxt   = left_tag;
      end else if (gt || !occupied) begin
        // This is the insertion slot; free cells further right take it too
        // but stay unoccupied.
        delay_nxt = cmd.new_delay;
        tag_nxt   = cmd.new_tag;
      end
    end else if (cmd.shift) begin
      delay_nxt = right_delay;
      tag_nxt   = right_tag;
    end
  end

  always_ff @(posedge clk) begin
    delay_r <= delay_nxt;
    tag_r   <= tag_nxt;
  end

endmodule

// ----- design/sorted_timer_queue.sv -----
// Sorted timer queue: holds up to CAPACITY pending timers ordered by delay.
// Input channel (in_valid/in_ready): in_operation selects add (with
// in_delay_seconds and in_tag) or timeout of the front timer.
// Result channel (out_valid/out_ready): one result item per input item with
// the delay to arm the timer with, the expired tag on timeout, a status code
// (ok, add rejected because full, timeout while empty) and the pending count.
// Each cell of the chain compares its delay with the new one and takes its
// left neighbor's entry, the new entry, or its right neighbor's entry, so an
// insertion or removal completes in the cycle the item is accepted.
// The result is registered and valid in the cycle after acceptance.
// Throughput: one item per cycle while out_ready is high; the output register
// holds a stalled result, and in_ready drops until it is taken.
// Reset clears the pending count and the output valid; entry contents need
// no reset since only occupied cells are ever read.
module sorted_timer_queue
  import stq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  logic [DELAY_W-1:0]  in_delay_seconds,
  input  logic [TAG_W-1:0]    in_tag,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_arm_valid,
  output logic [DELAY_W-1:0]  out_arm_seconds,
  output logic                out_expired_valid,
  output logic [TAG_W-1:0]    out_expired_tag,
  output logic [STATUS_W-1:0] out_status,
  output logic [PEND_W-1:0]   out_pending_count
);

  logic [DELAY_W-1:0] cell_delay [CAPACITY];
  logic [TAG_W-1:0]   cell_tag   [CAPACITY];
  logic               cell_gt    [CAPACITY];

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r;
  logic               arm_valid_r;
  logic [DELAY_W-1:0] arm_seconds_r;
  logic               exp_valid_r;
  logic [TAG_W-1:0]   exp_tag_r;
  logic [STATUS_W-1:0] status_r;
  logic [PEND_W-1:0]  pend_r;

  logic               accept, is_full, is_empty;
  cell_cmd_t          cmd;
  logic               res_arm_valid, res_exp_valid;
  logic [DELAY_W-1:0] res_arm_seconds;
  logic [TAG_W-1:0]   res_exp_tag;
  logic [STATUS_W-1:0] res_status;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);

  assign cmd.insert    = accept && (in_operation == OP_ADD) && !is_full;
  assign cmd.shift     = accept && (in_operation == OP_TIMEOUT) && !is_empty;
  assign cmd.new_delay = in_delay_seconds;
  assign cmd.new_tag   = in_tag;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic               l_gt;
      logic [DELAY_W-1:0] l_delay, r_delay;
      logic [TAG_W-1:0]   l_tag, r_tag;
      if (i == 0) begin : g_first
        assign l_gt    = 1'b0;
        assign l_delay = '0;
        assign l_tag   = '0;
      end else begin : g_mid
        assign l_gt    = cell_gt[i-1];
        assign l_delay = cell_delay[i-1];
        assign l_tag   = cell_tag[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign r_delay = cell_delay[i];
        assign r_tag   = cell_tag[i];
      end else begin : g_inner
        assign r_delay = cell_delay[i+1];
        assign r_tag   = cell_tag[i+1];
      end
      stq_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occupied    (count_r > CNT_W'(i)),
        .left_gt     (l_gt),
        .left_delay  (l_delay),
        .left_tag    (l_tag),
        .right_delay (r_delay),
        .right_tag   (r_tag),
        .delay_r     (cell_delay[i]),
        .tag_r       (cell_tag[i]),
        .gt          (cell_gt[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt       = count_r;
    res_arm_valid   = 1'b0;
    res_arm_seconds = '0;
    res_exp_valid   = 1'b0;
    res_exp_tag     = '0;
    res_status      = ST_OK;
    if (in_operation == OP_ADD) begin
      if (is_full) begin
        res_status = ST_FULL;
      end else begin
        count_nxt     = count_r + CNT_W'(1);
        res_arm_valid = 1'b1;
        // The new entry becomes the front when it is strictly smallest.
        if (is_empty || cell_gt[0]) begin
          res_arm_seconds = in_delay_seconds;
        end else begin
          res_arm_seconds = cell_delay[0];
        end
      end
    end else begin
      if (is_empty) begin
        res_status = ST_EMPTY;
      end else begin
        count_nxt     = count_r - CNT_W'(1);
        res_exp_valid = 1'b1;
        res_exp_tag   = cell_tag[0];
        if (count_r > CNT_W'(1)) begin
          res_arm_valid   = 1'b1;
          res_arm_seconds = cell_delay[1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      arm_valid_r   <= res_arm_valid;
      arm_seconds_r <= res_arm_seconds;
      exp_valid_r   <= res_exp_valid;
      exp_tag_r     <= res_exp_tag;
      status_r      <= res_status;
      pend_r        <= PEND_W'(count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_arm_valid     = arm_valid_r;
  assign out_arm_seconds   = arm_seconds_r;
  assign out_expired_valid = exp_valid_r;
  assign out_expired_tag   = exp_tag_r;
  assign out_status        = status_r;
  assign out_pending_count = pend_r;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import stq_pkg::*;

  localparam int RUN_LIMIT    = 600000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int PHASE_LEN    = 40;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic                arm_valid;
    logic [DELAY_W-1:0]  arm_seconds;
    logic                expired_valid;
    logic [TAG_W-1:0]    expired_tag;
    logic [STATUS_W-1:0] status;
    logic [PEND_W-1:0]   pending_count;
  } timer_result_t;

  typedef struct {
    logic               op;
    logic [DELAY_W-1:0] delay;
    logic [TAG_W-1:0]   tag;
    bit                 typed;
    timer_result_t      want;
  } directed_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_operation = OP_ADD;
  logic [DELAY_W-1:0]  in_delay_seconds = '0;
  logic [TAG_W-1:0]    in_tag = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_arm_valid;
  logic [DELAY_W-1:0]  out_arm_seconds;
  logic                out_expired_valid;
  logic [TAG_W-1:0]    out_expired_tag;
  logic [STATUS_W-1:0] out_status;
  logic [PEND_W-1:0]   out_pending_count;

  // Shadow copy of the timer list, kept sorted by delay.
  logic [DELAY_W-1:0] shadow_delay [CAPACITY];
  logic [TAG_W-1:0]   shadow_tag [CAPACITY];
  int unsigned        shadow_count = 0;

  timer_result_t      expected_results [$];
  directed_row_t      directed_rows [$];
  int                 mismatch_count = 0;
  int unsigned        cycle_count = 0;
  bit                 tx_idle = 1'b1;
  bit                 rx_idle = 1'b1;

  sorted_timer_queue dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_delay_seconds  (in_delay_seconds),
    .in_tag            (in_tag),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_arm_valid     (out_arm_valid),
    .out_arm_seconds   (out_arm_seconds),
    .out_expired_valid (out_expired_valid),
    .out_expired_tag   (out_expired_tag),
    .out_status        (out_status),
    .out_pending_count (out_pending_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("** sorted_timer_queue: FAILED **");
      $finish;
    end
  end

  function automatic timer_result_t apply_timer_op(input logic op,
                                                   input logic [DELAY_W-1:0] delay,
                                                   input logic [TAG_W-1:0] tag);
    timer_result_t r;
    int unsigned   pos;
    int unsigned   k;
    r = '0;
    if (op == OP_ADD) begin
      if (shadow_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // New timer goes behind every entry with an equal or smaller delay.
        pos = shadow_count;
        while (pos > 0 && shadow_delay[pos-1] > delay) pos--;
        for (k = shadow_count; k > pos; k--) begin
          shadow_delay[k] = shadow_delay[k-1];
          shadow_tag[k]   = shadow_tag[k-1];
        end
        shadow_delay[pos] = delay;
        shadow_tag[pos]   = tag;
        shadow_count++;
        r.arm_valid   = 1'b1;
        r.arm_seconds = shadow_delay[0];
        r.status      = ST_OK;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.expired_valid = 1'b1;
      r.expired_tag   = shadow_tag[0];
      for (k = 1; k < shadow_count; k++) begin
        shadow_delay[k-1] = shadow_delay[k];
        shadow_tag[k-1]   = shadow_tag[k];
      end
      shadow_count--;
      if (shadow_count > 0) begin
        r.arm_valid   = 1'b1;
        r.arm_seconds = shadow_delay[0];
      end
      r.status = ST_OK;
    end
    r.pending_count = PEND_W'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic add_row(input logic op, input int delay, input int tag, input bit typed,
                         input logic armv, input int arms, input logic expv, input int expt,
                         input logic [STATUS_W-1:0] st, input int cnt);
    directed_row_t row;
    row.op                 = op;
    row.delay              = DELAY_W'(delay);
    row.tag                = TAG_W'(tag);
    row.typed              = typed;
    row.want.arm_valid     = armv;
    row.want.arm_seconds   = DELAY_W'(arms);
    row.want.expired_valid = expv;
    row.want.expired_tag   = TAG_W'(expt);
    row.want.status        = st;
    row.want.pending_count = PEND_W'(cnt);
    directed_rows.push_back(row);
  endtask

  // Presents one item and returns at the edge where it is accepted. With hold set,
  // the sender first waits until every outstanding result has come back.
  task automatic send_item(input logic op, input logic [DELAY_W-1:0] delay,
                           input logic [TAG_W-1:0] tag, input bit hold);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap != 0 || hold) begin
      in_valid <= 1'b0;
      do @(negedge clk); while (hold && expected_results.size() != 0);
      repeat (gap - 1) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_delay_seconds <= delay;
    in_tag           <= tag;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // Result side: random back-pressure, then compare each item with the oldest prediction.
  initial begin
    int            stall;
    timer_result_t got;
    timer_result_t want;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = rx_idle ? $urandom_range(0, 11) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = {out_arm_valid, out_arm_seconds, out_expired_valid, out_expired_tag,
             out_status, out_pending_count};
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
      end else begin
        want = expected_results.pop_front();
        if (got.arm_valid !== want.arm_valid)
          report_mismatch($sformatf("arm_valid %b, want %b", got.arm_valid, want.arm_valid));
        if (got.arm_seconds !== want.arm_seconds)
          report_mismatch($sformatf("arm_seconds %0d, want %0d",
                                    got.arm_seconds, want.arm_seconds));
        if (got.expired_valid !== want.expired_valid)
          report_mismatch($sformatf("expired_valid %b, want %b",
                                    got.expired_valid, want.expired_valid));
        if (got.expired_tag !== want.expired_tag)
          report_mismatch($sformatf("expired_tag %h, want %h",
                                    got.expired_tag, want.expired_tag));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.pending_count !== want.pending_count)
          report_mismatch($sformatf("pending_count %0d, want %0d",
                                    got.pending_count, want.pending_count));
      end
    end
  end

  initial begin
    timer_result_t      predicted;
    logic               op;
    logic [DELAY_W-1:0] delay;
    logic [TAG_W-1:0]   tag;
    int unsigned        add_pct;

    // Directed table: empty timeout, a timeout that empties the list, extremes and
    // equal delays while filling to capacity, an add when full, then timeouts.
    add_row(OP_TIMEOUT, 0, 0, 1, 0, 0, 0, 0, ST_EMPTY, 0);
    add_row(OP_ADD, 5, 1, 1, 1, 5, 0, 0, ST_OK, 1);
    add_row(OP_TIMEOUT, 16'hFFFF, 16'hFFFF, 1, 0, 0, 1, 1, ST_OK, 0);
    add_row(OP_ADD, 16'hFFFF, 0, 1, 1, 16'hFFFF, 0, 0, ST_OK, 1);
    add_row(OP_ADD, 0, 16'hFFFF, 1, 1, 0, 0, 0, ST_OK, 2);
    add_row(OP_ADD, 100, 16'h1111, 0, 0, 0, 0, 0, ST_OK, 0);
    add_row(OP_ADD, 100, 16'h2222, 0, 0, 0, 0, 0, ST_OK, 0);
    add_row(OP_ADD, 100, 16'h3333, 0, 0, 0, 0, 0, ST_OK, 0);
    add_row(OP_ADD, 16'hFFFF, 16'h4444, 0, 0, 0, 0, 0, ST_OK, 0);
    add_row(OP_ADD, 0, 16'h5555, 0, 0, 0, 0, 0, ST_OK, 0);
    for (int i = 0; i < 9; i++)
      add_row(OP_ADD, 16'h8000 - i * 4099, 16'hA000 + i, 0, 0, 0, 0, 0, ST_OK, 0);
    add_row(OP_ADD, 16'h5A5A, 16'hA5A5, 1, 0, 0, 0, 0, ST_FULL, 16);
    add_row(OP_TIMEOUT, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0);
    add_row(OP_TIMEOUT, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].delay, directed_rows[i].tag, 1'b0);
      predicted = apply_timer_op(directed_rows[i].op, directed_rows[i].delay,
                                 directed_rows[i].tag);
      expected_results.push_back(directed_rows[i].typed ? directed_rows[i].want : predicted);
    end

    // Random part: phases lean toward adds or toward timeouts so the list keeps
    // swinging between empty and full; small delays make ties frequent.
    add_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        case ($urandom_range(0, 3))
          0: add_pct = 10;
          1: add_pct = 50;
          2: add_pct = 75;
          default: add_pct = 95;
        endcase
        tx_idle = ($urandom_range(0, 2) != 0);
        rx_idle = ($urandom_range(0, 2) != 0);
      end
      op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_TIMEOUT;
      case ($urandom_range(0, 3))
        0: delay = DELAY_W'($urandom_range(0, 15));
        1: delay = DELAY_W'($urandom_range(0, 255));
        2: delay = $urandom_range(0, 1) ? '1 : '0;
        default: delay = DELAY_W'($urandom);
      endcase
      tag = TAG_W'($urandom);
      send_item(op, delay, tag, (n % 400) == 200);
      expected_results.push_back(apply_timer_op(op, delay, tag));
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** sorted_timer_queue: PASSED **");
    end else begin
      $display("** sorted_timer_queue: FAILED **");
    end
    $finish;
  end

endmodule
